[sv/tbsd_pkg.sv]
// Package for the timed button sequence detector.
// Holds the history depth, action, flash and register codes, reset values and the item and register types.
// No dependencies.
package tbsd_pkg;

	// history of presses
	localparam int HIST_DEPTH = 4;
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

	// actions
	localparam logic [1:0] ACT_NONE     = 2'd0;
	localparam logic [1:0] ACT_AUTO     = 2'd1;
	localparam logic [1:0] ACT_AMBER    = 2'd2;
	localparam logic [1:0] ACT_DEGRADED = 2'd3;

	// red flash counts per confirmation
	localparam logic [2:0] FLASH_NONE     = 3'd0;
	localparam logic [2:0] FLASH_AUTO     = 3'd2;
	localparam logic [2:0] FLASH_AMBER    = 3'd3;
	localparam logic [2:0] FLASH_DEGRADED = 3'd4;

	// item kinds
	localparam logic KIND_PRESS = 1'b0;
	localparam logic KIND_POLL  = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_UP      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_DOWN    = 2'd3;

	// register reset values
	localparam logic [15:0] SHORT_WINDOW_RST = 16'd12000;
	localparam logic [15:0] LONG_WINDOW_RST  = 16'd18000;
	localparam logic [7:0]  CODE_UP_RST      = 8'd0;
	localparam logic [7:0]  CODE_DOWN_RST    = 8'd1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  button;
		logic [31:0] now_ms;
		logic        inhibited;
		logic        signal_busy;
		logic        degraded_allowed;
	} in_item_t;

	typedef struct packed {
		logic [1:0] confirm_action;
		logic [2:0] flash_count;
		logic       reject;
		logic [1:0] execute_action;
	} out_item_t;

	typedef struct packed {
		logic [15:0] short_window_ms;
		logic [15:0] long_window_ms;
		logic [7:0]  code_up;
		logic [7:0]  code_down;
	} cfg_t;

endpackage

[sv/tbsd_cfg_regs.sv]
// Configuration register file of the timed button sequence detector.
// Depends on tbsd_pkg for register indexes, reset values and cfg_t.
module tbsd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [tbsd_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [15:0]                   wr_data,
	output tbsd_pkg::cfg_t                cfg
);
	import tbsd_pkg::*;

	cfg_t cfg_q;

	// register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_window_ms <= SHORT_WINDOW_RST;
			cfg_q.long_window_ms  <= LONG_WINDOW_RST;
			cfg_q.code_up         <= CODE_UP_RST;
			cfg_q.code_down       <= CODE_DOWN_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_SHORT_WINDOW: cfg_q.short_window_ms <= wr_data;
				REG_LONG_WINDOW:  cfg_q.long_window_ms  <= wr_data;
				REG_CODE_UP:      cfg_q.code_up         <= wr_data[7:0];
				REG_CODE_DOWN:    cfg_q.code_down       <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/tbsd_core.sv]
// Press history, pending action and sequence matching of the detector.
// Evaluates one registered item per cycle unless a stall holds it, and updates state when fire moves it on.
// Depends on tbsd_pkg.
module tbsd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  tbsd_pkg::in_item_t  item,
	input  tbsd_pkg::cfg_t      cfg,
	output tbsd_pkg::out_item_t res
);
	import tbsd_pkg::*;

	logic [7:0]       codes_q [HIST_DEPTH];
	logic [31:0]      times_q [HIST_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [1:0]       pending_q;

	logic [HIST_DEPTH-1:0] stale;
	logic [CNT_W-1:0]      first, kept_pre, shift, kept;
	logic                  run;
	logic [7:0]            cc [HIST_DEPTH+1];
	logic [31:0]           ct [HIST_DEPTH+1];
	logic [7:0]            code_m3, code_m2, code_m1;
	logic [31:0]           time_m3, time_m2;
	logic                  deg_hit, tri_time, up3, dn3;
	logic [7:0]            codes_d [HIST_DEPTH];
	logic [31:0]           times_d [HIST_DEPTH];
	logic [CNT_W-1:0]      count_d;
	logic [1:0]            pending_d;
	logic                  hist_wr;

	// age check of each stored press against the long window
	always_comb begin
		for (int i = 0; i < HIST_DEPTH; i++) begin
			stale[i] = (item.now_ms - times_q[i]) > {16'd0, cfg.long_window_ms};
		end
	end

	// leading stale entries, plus one more when the history is still full
	always_comb begin
		run   = 1'b1;
		first = '0;
		for (int i = 0; i < HIST_DEPTH; i++) begin
			if (run && (i < int'(count_q)) && stale[i]) begin
				first = first + 1'b1;
			end else begin
				run = 1'b0;
			end
		end
		kept_pre = count_q - first;
		shift    = first + ((kept_pre == CNT_W'(HIST_DEPTH)) ? CNT_W'(1) : CNT_W'(0));
		kept     = count_q - shift;
	end

	// stored entries followed by the new press
	always_comb begin
		for (int i = 0; i <= HIST_DEPTH; i++) begin
			if ((i < HIST_DEPTH) && (i < int'(count_q))) begin
				cc[i] = codes_q[i % HIST_DEPTH];
				ct[i] = times_q[i % HIST_DEPTH];
			end else begin
				cc[i] = item.button;
				ct[i] = item.now_ms;
			end
		end
	end

	// entries just before the new press
	always_comb begin
		code_m3 = '0;
		code_m2 = '0;
		code_m1 = '0;
		time_m3 = '0;
		time_m2 = '0;
		for (int i = 0; i < HIST_DEPTH; i++) begin
			if (i + 3 == int'(count_q)) begin
				code_m3 = codes_q[i];
				time_m3 = times_q[i];
			end
			if (i + 2 == int'(count_q)) begin
				code_m2 = codes_q[i];
				time_m2 = times_q[i];
			end
			if (i + 1 == int'(count_q)) begin
				code_m1 = codes_q[i];
			end
		end
	end

	// sequence matching
	assign deg_hit = (kept >= CNT_W'(3))
		&& (code_m3 == cfg.code_up) && (code_m2 == cfg.code_down)
		&& (code_m1 == cfg.code_up) && (item.button == cfg.code_down)
		&& ((item.now_ms - time_m3) <= {16'd0, cfg.long_window_ms});
	assign tri_time = (kept >= CNT_W'(2))
		&& ((item.now_ms - time_m2) <= {16'd0, cfg.short_window_ms});
	assign up3 = (code_m2 == cfg.code_up) && (code_m1 == cfg.code_up)
		&& (item.button == cfg.code_up);
	assign dn3 = (code_m2 == cfg.code_down) && (code_m1 == cfg.code_down)
		&& (item.button == cfg.code_down);

	// shifted history with the new press appended
	always_comb begin
		for (int j = 0; j < HIST_DEPTH; j++) begin
			codes_d[j] = codes_q[j];
			times_d[j] = times_q[j];
			for (int i = 0; i <= HIST_DEPTH; i++) begin
				if (i == j + int'(shift)) begin
					codes_d[j] = cc[i];
					times_d[j] = ct[i];
				end
			end
		end
	end

	// per-item decision and result
	always_comb begin
		res       = '0;
		count_d   = count_q;
		pending_d = pending_q;
		hist_wr   = 1'b0;
		if (item.kind == KIND_POLL) begin
			if ((pending_q != ACT_NONE) && !item.signal_busy) begin
				res.execute_action = pending_q;
				pending_d          = ACT_NONE;
			end
		end else if (item.inhibited) begin
			count_d = '0;
		end else if (!item.signal_busy && (pending_q == ACT_NONE)) begin
			if (deg_hit) begin
				if (item.degraded_allowed) begin
					res.confirm_action = ACT_DEGRADED;
					res.flash_count    = FLASH_DEGRADED;
					pending_d          = ACT_DEGRADED;
				end else begin
					res.reject = 1'b1;
				end
				count_d = '0;
			end else if (tri_time && up3) begin
				res.confirm_action = ACT_AUTO;
				res.flash_count    = FLASH_AUTO;
				pending_d          = ACT_AUTO;
				count_d            = '0;
			end else if (tri_time && dn3) begin
				res.confirm_action = ACT_AMBER;
				res.flash_count    = FLASH_AMBER;
				pending_d          = ACT_AMBER;
				count_d            = '0;
			end else begin
				count_d = kept + 1'b1;
				hist_wr = 1'b1;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pending_q <= ACT_NONE;
		end else if (fire) begin
			count_q   <= count_d;
			pending_q <= pending_d;
		end
	end

	// history payload, no reset
	always_ff @(posedge clk) begin
		if (fire && hist_wr) begin
			for (int j = 0; j < HIST_DEPTH; j++) begin
				codes_q[j] <= codes_d[j];
				times_q[j] <= times_d[j];
			end
		end
	end

endmodule

[sv/timed_button_sequence_detector.sv]
// Timed button sequence detector: top level with input and result registers.
// Instantiates tbsd_cfg_regs and tbsd_core; depends on tbsd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries press or poll transactions.
//   Output channel (out_valid/out_ready/out_data) returns exactly one result
//   transaction per input transaction, in order.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
//   window and button-code registers; cfg_ready is always high. Write only
//   while no transaction is in flight.
// Path: an accepted input is held in the input register, then loaded into the
//   result register when it advances, which raises out_valid. The decision
//   logic sits between the two registers.
// Throughput: one transaction per cycle while out_ready stays high; state
//   written when one item advances is seen by the next item.
// Stall: when out_ready is low the result register holds, the input register
//   still fills, and in_ready drops only when both are occupied.
// Reset: arst_n clears the history count, pending action, valid flags and
//   restores register defaults (12000 ms, 18000 ms, up code 0, down code 1).
module timed_button_sequence_detector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  tbsd_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output tbsd_pkg::out_item_t            out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tbsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);
	import tbsd_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t res_s2;
	out_item_t res;
	cfg_t      cfg;
	logic      advance;

	assign cfg_ready = 1'b1;

	tbsd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// item in stage 1 moves on when the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	tbsd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

[test/tb_top.sv]
// Self-checking testbench for timed_button_sequence_detector.
// Drives press and poll transactions, rewrites the window and code registers and
// checks every result against a predictor of its own. Depends on tbsd_pkg and the detector top level.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tbsd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int END_SETTLE     = 10;
	localparam int N_PHASES       = 6;
	localparam int PHASE_ITEMS    = 250;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	timed_button_sequence_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// predictor copy of registers and history
	logic [15:0] win_short;
	logic [15:0] win_long;
	logic [7:0]  code_a;
	logic [7:0]  code_b;
	logic [7:0]  hist_code [HIST_DEPTH];
	logic [31:0] hist_time [HIST_DEPTH];
	int          hist_cnt;
	logic [1:0]  held_action;

	out_item_t   verdict_q [$];
	logic [31:0] clock_ms;
	bit          tx_idle;
	bit          rx_idle;
	int          n_fail;
	int          n_items;
	int          n_writes;
	int          n_auto;
	int          n_amber;
	int          n_degraded;
	int          n_reject;
	int          n_release;
	int          quiet_cycles;

	function automatic int draw_wait(input bit enabled);
		return enabled ? $urandom_range(0, 19) : 0;
	endfunction

	// age of a stored press, wrapping modulo 2^32
	function automatic logic [31:0] age_ms(input logic [31:0] now, input logic [31:0] stamp);
		return now - stamp;
	endfunction

	function automatic void drop_oldest(input int k);
		if (k == 0 || k > hist_cnt)
			return;
		for (int i = k; i < hist_cnt; i++) begin
			hist_code[i-k] = hist_code[i];
			hist_time[i-k] = hist_time[i];
		end
		hist_cnt -= k;
	endfunction

	// expected result of one transaction; updates the predictor state
	function automatic out_item_t predict_verdict(input in_item_t it);
		out_item_t v;
		int        first;
		int        n;
		v = '0;
		if (it.kind == KIND_POLL) begin
			if (held_action != ACT_NONE && !it.signal_busy) begin
				v.execute_action = held_action;
				held_action = ACT_NONE;
				n_release++;
			end
		end else if (it.inhibited) begin
			hist_cnt = 0;
		end else if (!it.signal_busy && held_action == ACT_NONE) begin
			// purge stale presses, make room, append
			first = 0;
			while (first < hist_cnt && age_ms(it.now_ms, hist_time[first]) > win_long)
				first++;
			drop_oldest(first);
			if (hist_cnt >= HIST_DEPTH)
				drop_oldest(hist_cnt - (HIST_DEPTH - 1));
			hist_code[hist_cnt] = it.button;
			hist_time[hist_cnt] = it.now_ms;
			hist_cnt++;
			n = hist_cnt;
			// up.down.up.down takes priority over the triples
			if (n >= 4 && hist_code[n-4] == code_a && hist_code[n-3] == code_b &&
			    hist_code[n-2] == code_a && hist_code[n-1] == code_b &&
			    age_ms(it.now_ms, hist_time[n-4]) <= win_long) begin
				if (it.degraded_allowed) begin
					v.confirm_action = ACT_DEGRADED;
					v.flash_count    = FLASH_DEGRADED;
					held_action      = ACT_DEGRADED;
					n_degraded++;
				end else begin
					v.reject = 1'b1;
					n_reject++;
				end
				hist_cnt = 0;
			end else if (n >= 3 && age_ms(it.now_ms, hist_time[n-3]) <= win_short) begin
				if (hist_code[n-3] == code_a && hist_code[n-2] == code_a &&
				    hist_code[n-1] == code_a) begin
					v.confirm_action = ACT_AUTO;
					v.flash_count    = FLASH_AUTO;
					n_auto++;
				end else if (hist_code[n-3] == code_b && hist_code[n-2] == code_b &&
				             hist_code[n-1] == code_b) begin
					v.confirm_action = ACT_AMBER;
					v.flash_count    = FLASH_AMBER;
					n_amber++;
				end
				if (v.confirm_action != ACT_NONE) begin
					held_action = v.confirm_action;
					hist_cnt    = 0;
				end
			end
		end
		return v;
	endfunction

	function automatic in_item_t make_press(input logic [7:0] code, input logic [31:0] stamp,
	                                        input logic allow);
		in_item_t it;
		it = '0;
		it.kind             = KIND_PRESS;
		it.button           = code;
		it.now_ms           = stamp;
		it.degraded_allowed = allow;
		return it;
	endfunction

	// poll; fields a poll ignores get random values
	function automatic in_item_t make_poll(input logic busy, input logic inh);
		in_item_t it;
		it = '0;
		it.kind             = KIND_POLL;
		it.button           = 8'($urandom_range(0, 255));
		it.now_ms           = $urandom;
		it.degraded_allowed = 1'($urandom_range(0, 1));
		it.signal_busy      = busy;
		it.inhibited        = inh;
		return it;
	endfunction

	// one input transaction; valid stays high when the next one follows at once
	task automatic send_item(input in_item_t it);
		int gap;
		gap = draw_wait(tx_idle);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		verdict_q.push_back(predict_verdict(it));
		n_items++;
	endtask

	// hold input until every expected result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SHORT_WINDOW: win_short = value;
			REG_LONG_WINDOW:  win_long  = value;
			REG_CODE_UP:      code_a    = value[7:0];
			REG_CODE_DOWN:    code_b    = value[7:0];
			default: ;
		endcase
		n_writes++;
		@(posedge clk);
	endtask

	// full register set; junk in the upper byte of the code writes
	task automatic configure(input logic [15:0] s_win, input logic [15:0] l_win,
	                         input logic [7:0] up, input logic [7:0] down);
		logic [7:0] junk_a;
		logic [7:0] junk_b;
		junk_a = 8'($urandom_range(0, 255));
		junk_b = 8'($urandom_range(0, 255));
		drain_results();
		write_register(REG_SHORT_WINDOW, s_win);
		write_register(REG_LONG_WINDOW, l_win);
		write_register(REG_CODE_UP, {junk_a, up});
		write_register(REG_CODE_DOWN, {junk_b, down});
	endtask

	// a triple or up.down.up.down with a span within or just past its window, then release polls
	task automatic send_sequence(input bit broken);
		int          pat;
		int          len;
		int          k;
		int          how;
		logic [31:0] w;
		logic [31:0] lw;
		logic [31:0] span;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] base;
		logic [31:0] stamps [4];
		logic [7:0]  codes [4];
		logic        allow;
		in_item_t    it;
		pat  = $urandom_range(0, 2);
		len  = (pat == 2) ? 4 : 3;
		w    = (pat == 2) ? win_long : win_short;
		lw   = win_long;
		span = ($urandom_range(0, 3) == 0) ? w + $urandom_range(0, 2) : $urandom_range(0, w);
		a    = $urandom_range(0, span);
		b    = $urandom_range(a, span);
		clock_ms += $urandom_range(0, lw + lw / 2 + 2);
		base = clock_ms;
		stamps[0] = base;
		stamps[1] = base + a;
		stamps[2] = (len == 3) ? base + span : base + b;
		stamps[3] = base + span;
		for (int i = 0; i < 4; i++) begin
			if (pat == 0)
				codes[i] = code_a;
			else if (pat == 1)
				codes[i] = code_b;
			else
				codes[i] = (i % 2 == 0) ? code_a : code_b;
		end
		clock_ms = base + span;
		allow = 1'($urandom_range(0, 1));
		k   = broken ? $urandom_range(0, len - 1) : -1;
		how = $urandom_range(0, 3);
		for (int i = 0; i < len; i++) begin
			it = make_press(codes[i], stamps[i], allow);
			if (i == k) begin
				case (how)
					0: it.button      = 8'($urandom_range(0, 255));
					1: it.inhibited   = 1'b1;
					2: it.signal_busy = 1'b1;
					default: it.kind  = KIND_POLL;
				endcase
			end
			send_item(it);
		end
		// release: sometimes busy first, sometimes a press that is ignored while an action is held
		if ($urandom_range(0, 2) == 0)
			send_item(make_poll(1'b1, 1'($urandom_range(0, 1))));
		if ($urandom_range(0, 3) == 0)
			send_item(make_press(codes[0], clock_ms, allow));
		if ($urandom_range(0, 7) != 0)
			send_item(make_poll(1'b0, 1'($urandom_range(0, 1))));
	endtask

	task automatic send_noise();
		in_item_t    it;
		int          sel;
		logic [31:0] lw;
		it  = '0;
		lw  = win_long;
		sel = $urandom_range(0, 2);
		it.kind   = ($urandom_range(0, 3) == 0) ? KIND_POLL : KIND_PRESS;
		it.button = (sel == 0) ? code_a : (sel == 1) ? code_b : 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) begin
			it.now_ms = $urandom;
		end else begin
			clock_ms += $urandom_range(0, lw + 2);
			it.now_ms = clock_ms;
		end
		it.inhibited        = ($urandom_range(0, 9) == 0);
		it.signal_busy      = ($urandom_range(0, 5) == 0);
		it.degraded_allowed = 1'($urandom_range(0, 1));
		send_item(it);
	endtask

	// reset register values: each sequence, holds, releases, reject
	task automatic test_default_sequences();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		// span equal to the short window confirms automatic
		send_item(make_press(code_a, 32'd1000, 1'b1));
		send_item(make_press(code_a, 32'd5000, 1'b1));
		send_item(make_press(code_a, 32'd13000, 1'b1));
		send_item(make_poll(1'b1, 1'b0));
		send_item(make_poll(1'b0, 1'b1));
		send_item(make_poll(1'b0, 1'b0));
		// first triple one ms too slow, the next one fits
		send_item(make_press(code_b, 32'd20000, 1'b0));
		send_item(make_press(code_b, 32'd25000, 1'b0));
		send_item(make_press(code_b, 32'd32001, 1'b0));
		send_item(make_press(code_b, 32'd33000, 1'b0));
		send_item(make_poll(1'b0, 1'b0));
		// degraded allowed, then refused
		send_item(make_press(code_a, 32'd40000, 1'b1));
		send_item(make_press(code_b, 32'd45000, 1'b1));
		send_item(make_press(code_a, 32'd50000, 1'b1));
		send_item(make_press(code_b, 32'd58000, 1'b1));
		send_item(make_poll(1'b0, 1'b0));
		send_item(make_press(code_a, 32'd70000, 1'b0));
		send_item(make_press(code_b, 32'd75000, 1'b0));
		send_item(make_press(code_a, 32'd80000, 1'b0));
		send_item(make_press(code_b, 32'd88000, 1'b0));
	endtask

	// zero and full windows, top button code, timestamp wrap and stale stamps
	task automatic test_register_extremes();
		configure(16'd0, 16'd0, 8'd255, 8'd0);
		send_item(make_press(code_a, 32'hFFFF_FFFF, 1'b1));
		send_item(make_press(code_a, 32'hFFFF_FFFF, 1'b1));
		send_item(make_press(code_a, 32'hFFFF_FFFF, 1'b1));
		send_item(make_poll(1'b0, 1'b0));
		configure(16'hFFFF, 16'hFFFF, 8'd255, 8'd0);
		// a stamp later than now reads as very old and is purged
		send_item(make_press(code_a, 32'd200, 1'b1));
		send_item(make_press(code_a, 32'd100, 1'b1));
		send_item(make_press(code_a, 32'd101, 1'b1));
		send_item(make_press(code_a, 32'd102, 1'b1));
		send_item(make_poll(1'b0, 1'b0));
	endtask

	// random phases, each with its own register set
	task automatic test_random_traffic();
		int         goal;
		int         pick;
		logic [15:0] rs;
		logic [15:0] rl;
		logic [7:0]  ru;
		logic [7:0]  rd;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			rs = 16'($urandom_range(0, 65535));
			rl = 16'($urandom_range(0, 65535));
			ru = 8'($urandom_range(0, 255));
			rd = 8'($urandom_range(0, 255));
			case (ph)
				0: configure(16'd0, 16'hFFFF, 8'd0, 8'd255);
				1: configure(16'hFFFF, 16'd0, 8'd255, 8'd255);
				2: configure(16'hFFFF, 16'hFFFF, ru, rd);
				4: configure(rs, rl, ru, ru);
				default: configure(rs, rl, ru, rd);
			endcase
			// phase 2 runs back to back on both sides
			tx_idle  = (ph != 2);
			rx_idle  = (ph != 2);
			clock_ms = $urandom;
			goal     = n_items + PHASE_ITEMS;
			while (n_items < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					send_sequence(1'b0);
				else if (pick < 75)
					send_sequence(1'b1);
				else if (pick < 98)
					send_noise();
				else
					drain_results();
				if (ph != 2 && $urandom_range(0, 39) == 0)
					tx_idle = !tx_idle;
				if (ph != 2 && $urandom_range(0, 39) == 0)
					rx_idle = !rx_idle;
			end
		end
	endtask

	task automatic compare_verdict(input out_item_t got);
		out_item_t want;
		if (verdict_q.size() == 0) begin
			$error("result with nothing expected: confirm %0d flash %0d reject %0d execute %0d",
			       got.confirm_action, got.flash_count, got.reject, got.execute_action);
			n_fail++;
			return;
		end
		want = verdict_q.pop_front();
		if (got.confirm_action !== want.confirm_action) begin
			$error("confirm_action: expected %0d, got %0d", want.confirm_action,
			       got.confirm_action);
			n_fail++;
		end
		if (got.flash_count !== want.flash_count) begin
			$error("flash_count: expected %0d, got %0d", want.flash_count, got.flash_count);
			n_fail++;
		end
		if (got.reject !== want.reject) begin
			$error("reject: expected %0d, got %0d", want.reject, got.reject);
			n_fail++;
		end
		if (got.execute_action !== want.execute_action) begin
			$error("execute_action: expected %0d, got %0d", want.execute_action,
			       got.execute_action);
			n_fail++;
		end
	endtask

	// result side: random stall per transaction, check at acceptance
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(rx_idle);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			compare_verdict(out_data);
		end
	end

	// watchdog on cycles without any accepted transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("FAIL timed_button_sequence_detector");
					$finish;
				end
			end
		end
	end

	// reset, tests in turn, drain and verdict
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_SHORT_WINDOW;
		cfg_data     = '0;
		quiet_cycles = 0;
		win_short    = SHORT_WINDOW_RST;
		win_long     = LONG_WINDOW_RST;
		code_a       = CODE_UP_RST;
		code_b       = CODE_DOWN_RST;
		hist_cnt     = 0;
		held_action  = ACT_NONE;
		clock_ms     = '0;
		tx_idle      = 1'b1;
		rx_idle      = 1'b1;
		for (int i = 0; i < HIST_DEPTH; i++) begin
			hist_code[i] = '0;
			hist_time[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_sequences();
		test_register_extremes();
		test_random_traffic();

		drain_results();
		repeat (END_SETTLE) @(posedge clk);
		$display("covered %0d transactions over %0d register writes and %0d window settings",
		         n_items, n_writes, N_PHASES + 2);
		$display("confirms: %0d automatic, %0d amber, %0d degraded; %0d rejects, %0d releases",
		         n_auto, n_amber, n_degraded, n_reject, n_release);
		if (n_fail == 0)
			$display("PASS timed_button_sequence_detector");
		else
			$display("FAIL timed_button_sequence_detector");
		$finish;
	end

endmodule
